@@ hw/rtl/plbt_pkg.sv @@
package plbt_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int Y_WIDTH         = 16;
    localparam int MODE_WIDTH      = 3;
    localparam int STATUS_WIDTH    = 3;

    localparam logic [MODE_WIDTH-1:0] MODE_EVAL   = 3'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_INSERT = 3'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_REMOVE = 3'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_MOVE_X = 3'd3;
    localparam logic [MODE_WIDTH-1:0] MODE_SET_Y  = 3'd4;

    localparam logic [STATUS_WIDTH-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_WIDTH-1:0] STAT_NOT_FOUND = 3'd1;
    localparam logic [STATUS_WIDTH-1:0] STAT_NO_ROOM   = 3'd2;
    localparam logic [STATUS_WIDTH-1:0] STAT_FULL      = 3'd3;
    localparam logic [STATUS_WIDTH-1:0] STAT_RANGE     = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS,
        ST_TAIL,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    // one step of the chain: shift left, and up to two writes at wa0 / wa1
    typedef struct packed {
        logic shift;
        logic we0;
        logic we1;
    } chain_ctl_t;

endpackage

@@ hw/rtl/plbt_cell.sv @@
module plbt_cell #(
    parameter int CW  = plbt_pkg::COORD_WIDTH_DEF,
    parameter int AW  = 6,
    parameter int IDX = 0
) (
    input  logic                              aclk,
    input  plbt_pkg::chain_ctl_t              ctl,
    input  logic [AW-1:0]                     wa0,
    input  logic [AW-1:0]                     wa1,
    input  logic signed [CW-1:0]              d0_x,
    input  logic signed [plbt_pkg::Y_WIDTH-1:0] d0_y,
    input  logic signed [CW-1:0]              d1_x,
    input  logic signed [plbt_pkg::Y_WIDTH-1:0] d1_y,
    input  logic signed [CW-1:0]              nb_x,
    input  logic signed [plbt_pkg::Y_WIDTH-1:0] nb_y,
    output logic signed [CW-1:0]              x_q,
    output logic signed [plbt_pkg::Y_WIDTH-1:0] y_q
);

    logic signed [CW-1:0]               x_reg, x_next;
    logic signed [plbt_pkg::Y_WIDTH-1:0] y_reg, y_next;

    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        if (ctl.we0 && wa0 == AW'(IDX)) begin
            x_next = d0_x;
            y_next = d0_y;
        end else if (ctl.we1 && wa1 == AW'(IDX)) begin
            x_next = d1_x;
            y_next = d1_y;
        end else if (ctl.shift) begin
            x_next = nb_x;
            y_next = nb_y;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign x_q = x_reg;
    assign y_q = y_reg;

endmodule

@@ hw/rtl/plbt_chain.sv @@
module plbt_chain #(
    parameter int DEPTH = plbt_pkg::TABLE_DEPTH_DEF,
    parameter int CW    = plbt_pkg::COORD_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH + 1)
) (
    input  logic                                aclk,
    input  plbt_pkg::chain_ctl_t                ctl,
    input  logic [AW-1:0]                       wa0,
    input  logic [AW-1:0]                       wa1,
    input  logic signed [CW-1:0]                d0_x,
    input  logic signed [plbt_pkg::Y_WIDTH-1:0] d0_y,
    input  logic signed [CW-1:0]                d1_x,
    input  logic signed [plbt_pkg::Y_WIDTH-1:0] d1_y,
    output logic signed [CW-1:0]                head_x,
    output logic signed [plbt_pkg::Y_WIDTH-1:0] head_y,
    output logic signed [CW-1:0]                next_x
);

    logic signed [CW-1:0]                cx [DEPTH+1];
    logic signed [plbt_pkg::Y_WIDTH-1:0] cy [DEPTH+1];

    // nothing shifts in behind the last cell
    assign cx[DEPTH] = '0;
    assign cy[DEPTH] = '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        plbt_cell #(.CW(CW), .AW(AW), .IDX(i)) u_cell (
            .aclk (aclk),
            .ctl  (ctl),
            .wa0  (wa0),
            .wa1  (wa1),
            .d0_x (d0_x),
            .d0_y (d0_y),
            .d1_x (d1_x),
            .d1_y (d1_y),
            .nb_x (cx[i+1]),
            .nb_y (cy[i+1]),
            .x_q  (cx[i]),
            .y_q  (cy[i])
        );
    end

    assign head_x = cx[0];
    assign head_y = cy[0];
    assign next_x = cx[1];

endmodule

@@ hw/rtl/piecewise_linear_breakpoint_table_core.sv @@
// A request walks the table once through the cell chain, one vertex a cycle, before its
// result is loaded; an insert at the tail also appends the vertex after the walk, and an
// unused mode or an insert into a full table skips the walk. Interpolating evaluates
// add a multiply step and a restoring divider over the product width before the load.
// One request at a time: the next is taken the cycle after the result is loaded.
// Synchronous active-low reset empties the table.
module piecewise_linear_breakpoint_table_core #(
    parameter int TABLE_DEPTH = plbt_pkg::TABLE_DEPTH_DEF,
    parameter int COORD_WIDTH = plbt_pkg::COORD_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [plbt_pkg::MODE_WIDTH-1:0]        s_mode,
    input  logic signed [COORD_WIDTH-1:0]          s_x,
    input  logic signed [plbt_pkg::Y_WIDTH-1:0]    s_y,
    input  logic signed [COORD_WIDTH-1:0]          s_new_x,
    input  logic signed [plbt_pkg::Y_WIDTH-1:0]    s_new_y,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [plbt_pkg::Y_WIDTH-1:0]    m_value,
    output logic [plbt_pkg::STATUS_WIDTH-1:0]      m_status,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]       m_vertex_count
);

    localparam int CW = COORD_WIDTH;
    localparam int YW = plbt_pkg::Y_WIDTH;
    localparam int AW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = CW + 1 + YW + 1;         // product width
    localparam int DCW = $clog2(PW + 1);

    plbt_pkg::state_t state_reg, state_next;

    logic [plbt_pkg::MODE_WIDTH-1:0] mode_reg, mode_next;
    logic signed [CW-1:0] qx_reg, qx_next, nx_reg, nx_next;
    logic signed [YW-1:0] qy_reg, qy_next, ny_reg, ny_next;
    logic [AW-1:0] cnt_reg, cnt_next, old_reg, old_next, k_reg, k_next;
    logic done_reg, done_next, interp_reg, interp_next;
    logic [plbt_pkg::STATUS_WIDTH-1:0] st_reg, st_next;
    logic signed [YW-1:0] val_reg, val_next;
    logic signed [CW-1:0] px_reg, px_next, x0_reg, x0_next, x1_reg, x1_next;
    logic signed [YW-1:0] py_reg, py_next, y0_reg, y0_next, y1_reg, y1_next;
    logic [PW-1:0] quo_reg, quo_next;
    logic [CW+1:0] rem_reg, rem_next;
    logic [CW:0] den_reg, den_next;
    logic neg_reg, neg_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic m_valid_reg, m_valid_next;
    logic signed [YW-1:0] m_value_reg, m_value_next;
    logic [plbt_pkg::STATUS_WIDTH-1:0] m_status_reg, m_status_next;
    logic [AW-1:0] m_count_reg, m_count_next;

    plbt_pkg::chain_ctl_t ctl;
    logic [AW-1:0] wa0, wa1;
    logic signed [CW-1:0] d0_x, d1_x, head_x, next_x;
    logic signed [YW-1:0] d0_y, d1_y, head_y;

    plbt_chain #(.DEPTH(TABLE_DEPTH), .CW(CW), .AW(AW)) u_chain (
        .aclk   (aclk),
        .ctl    (ctl),
        .wa0    (wa0),
        .wa1    (wa1),
        .d0_x   (d0_x),
        .d0_y   (d0_y),
        .d1_x   (d1_x),
        .d1_y   (d1_y),
        .head_x (head_x),
        .head_y (head_y),
        .next_x (next_x)
    );

    logic signed [CW:0] hx_e, nxx_e, px_e, qx_e, t_e;
    logic first, has_next, last, match_x, match_xy;
    logic signed [PW-1:0] prod;
    logic [PW-1:0] prod_mag;
    logic [CW+1:0] r_try;
    logic q_bit;
    logic signed [YW+1:0] sum;
    logic [PW-1:0] q_res;

    always_comb begin
        hx_e     = {head_x[CW-1], head_x};
        nxx_e    = {next_x[CW-1], next_x};
        px_e     = {px_reg[CW-1], px_reg};
        qx_e     = {qx_reg[CW-1], qx_reg};
        first    = (k_reg == '0);
        has_next = ({1'b0, k_reg} + (AW+1)'(1)) < {1'b0, old_reg};
        last     = ({1'b0, k_reg} + (AW+1)'(1)) == {1'b0, old_reg};
        match_x  = (head_x == qx_reg);
        match_xy = match_x && (qy_reg[YW-1] || head_y == qy_reg);
        prod     = $signed({qx_e - {x0_reg[CW-1], x0_reg}})
                 * $signed({y1_reg[YW-1], y1_reg} - {y0_reg[YW-1], y0_reg});
        prod_mag = prod[PW-1] ? PW'(-prod) : PW'(prod);
        r_try    = {rem_reg[CW:0], quo_reg[PW-1]};
        q_bit    = (r_try >= {1'b0, den_reg});
        q_res    = neg_reg ? PW'(-$signed(quo_reg)) : quo_reg;
        sum      = {{2{y0_reg[YW-1]}}, y0_reg} + $signed(q_res[YW+1:0]);
        t_e      = {nx_reg[CW-1], nx_reg};
        if (!first && t_e < px_e + (CW+1)'(1)) begin
            t_e = px_e + (CW+1)'(1);
        end
        if (has_next && t_e > nxx_e - (CW+1)'(1)) begin
            t_e = nxx_e - (CW+1)'(1);
        end
    end

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        qx_next      = qx_reg;
        qy_next      = qy_reg;
        nx_next      = nx_reg;
        ny_next      = ny_reg;
        cnt_next     = cnt_reg;
        old_next     = old_reg;
        k_next       = k_reg;
        done_next    = done_reg;
        interp_next  = interp_reg;
        st_next      = st_reg;
        val_next     = val_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        x0_next      = x0_reg;
        y0_next      = y0_reg;
        x1_next      = x1_reg;
        y1_next      = y1_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        den_next     = den_reg;
        neg_next     = neg_reg;
        dcnt_next    = dcnt_reg;
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        m_status_next = m_status_reg;
        m_count_next = m_count_reg;
        ctl          = '0;
        wa0          = cnt_reg - AW'(1);
        wa1          = cnt_reg;
        d0_x         = head_x;
        d0_y         = head_y;
        d1_x         = head_x;
        d1_y         = head_y;
        s_ready      = (state_reg == plbt_pkg::ST_IDLE);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            plbt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    mode_next   = s_mode;
                    qx_next     = s_x;
                    qy_next     = s_y;
                    nx_next     = s_new_x;
                    ny_next     = s_new_y;
                    old_next    = cnt_reg;
                    k_next      = '0;
                    done_next   = 1'b0;
                    interp_next = 1'b0;
                    st_next     = plbt_pkg::STAT_OK;
                    val_next    = '0;
                    if (s_mode > plbt_pkg::MODE_SET_Y) begin
                        state_next = plbt_pkg::ST_OUT;
                    end else if (s_mode == plbt_pkg::MODE_INSERT
                                 && {1'b0, cnt_reg} >= (AW+1)'(TABLE_DEPTH)) begin
                        st_next    = plbt_pkg::STAT_FULL;
                        state_next = plbt_pkg::ST_OUT;
                    end else if (cnt_reg == '0) begin
                        if (s_mode == plbt_pkg::MODE_INSERT) begin
                            state_next = plbt_pkg::ST_TAIL;
                        end else begin
                            st_next = (s_mode == plbt_pkg::MODE_EVAL)
                                    ? plbt_pkg::STAT_RANGE : plbt_pkg::STAT_NOT_FOUND;
                            state_next = plbt_pkg::ST_OUT;
                        end
                    end else begin
                        state_next = plbt_pkg::ST_PASS;
                    end
                end
            end

            plbt_pkg::ST_PASS: begin
                // pop the head vertex, append what follows from it at the tail
                ctl.shift = 1'b1;
                ctl.we0   = 1'b1;
                cnt_next  = cnt_reg;
                px_next   = head_x;
                py_next   = head_y;
                if (!done_reg) begin
                    case (mode_reg)
                        plbt_pkg::MODE_EVAL: begin
                            if (match_x) begin
                                val_next  = head_y;
                                done_next = 1'b1;
                            end else if (head_x > qx_reg) begin
                                done_next = 1'b1;
                                if (first) begin
                                    st_next = plbt_pkg::STAT_RANGE;
                                end else begin
                                    interp_next = 1'b1;
                                    x0_next = px_reg;
                                    y0_next = py_reg;
                                    x1_next = head_x;
                                    y1_next = head_y;
                                end
                            end
                        end
                        plbt_pkg::MODE_INSERT: begin
                            if (match_x) begin
                                done_next = 1'b1;
                                if (qx_reg != {1'b1, {(CW-1){1'b0}}}
                                    && (first || px_e < qx_e - (CW+1)'(1))) begin
                                    ctl.we1  = 1'b1;
                                    d0_x     = qx_reg - CW'(1);
                                    d0_y     = qy_reg;
                                    cnt_next = cnt_reg + AW'(1);
                                end else if (qx_reg != {1'b0, {(CW-1){1'b1}}}
                                    && (!has_next || nxx_e > qx_e + (CW+1)'(1))) begin
                                    ctl.we1  = 1'b1;
                                    d1_x     = qx_reg + CW'(1);
                                    d1_y     = qy_reg;
                                    cnt_next = cnt_reg + AW'(1);
                                end else begin
                                    st_next = plbt_pkg::STAT_NO_ROOM;
                                end
                            end else if (head_x > qx_reg) begin
                                done_next = 1'b1;
                                ctl.we1   = 1'b1;
                                d0_x      = qx_reg;
                                d0_y      = qy_reg;
                                cnt_next  = cnt_reg + AW'(1);
                            end
                        end
                        plbt_pkg::MODE_REMOVE: begin
                            if (match_xy) begin
                                done_next = 1'b1;
                                ctl.we0   = 1'b0;
                                cnt_next  = cnt_reg - AW'(1);
                            end
                        end
                        plbt_pkg::MODE_MOVE_X: begin
                            if (match_x) begin
                                done_next = 1'b1;
                                d0_x      = t_e[CW-1:0];
                            end
                        end
                        default: begin
                            if (match_xy) begin
                                done_next = 1'b1;
                                d0_y      = ny_reg;
                            end
                        end
                    endcase
                end
                k_next = k_reg + AW'(1);
                if (last) begin
                    if (done_reg || done_next) begin
                        state_next = (interp_next) ? plbt_pkg::ST_MUL : plbt_pkg::ST_OUT;
                    end else if (mode_reg == plbt_pkg::MODE_INSERT) begin
                        state_next = plbt_pkg::ST_TAIL;
                    end else begin
                        st_next = (mode_reg == plbt_pkg::MODE_EVAL)
                                ? plbt_pkg::STAT_RANGE : plbt_pkg::STAT_NOT_FOUND;
                        state_next = plbt_pkg::ST_OUT;
                    end
                end
            end

            plbt_pkg::ST_TAIL: begin
                ctl.we0    = 1'b1;
                wa0        = cnt_reg;
                d0_x       = qx_reg;
                d0_y       = qy_reg;
                cnt_next   = cnt_reg + AW'(1);
                state_next = plbt_pkg::ST_OUT;
            end

            plbt_pkg::ST_MUL: begin
                quo_next   = prod_mag;
                neg_next   = prod[PW-1];
                rem_next   = '0;
                den_next   = (CW+1)'({x1_reg[CW-1], x1_reg} - {x0_reg[CW-1], x0_reg});
                dcnt_next  = '0;
                state_next = plbt_pkg::ST_DIV;
            end

            plbt_pkg::ST_DIV: begin
                if (dcnt_reg == DCW'(PW)) begin
                    val_next   = sum[YW-1:0];
                    state_next = plbt_pkg::ST_OUT;
                end else begin
                    rem_next  = q_bit ? (r_try - {1'b0, den_reg}) : r_try;
                    quo_next  = {quo_reg[PW-2:0], q_bit};
                    dcnt_next = dcnt_reg + DCW'(1);
                end
            end

            plbt_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = (st_reg == plbt_pkg::STAT_OK) ? val_reg : '0;
                    m_status_next = st_reg;
                    m_count_next  = cnt_reg;
                    state_next    = plbt_pkg::ST_IDLE;
                end
            end

            default: state_next = plbt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= plbt_pkg::ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        qx_reg       <= qx_next;
        qy_reg       <= qy_next;
        nx_reg       <= nx_next;
        ny_reg       <= ny_next;
        old_reg      <= old_next;
        k_reg        <= k_next;
        done_reg     <= done_next;
        interp_reg   <= interp_next;
        st_reg       <= st_next;
        val_reg      <= val_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        x0_reg       <= x0_next;
        y0_reg       <= y0_next;
        x1_reg       <= x1_next;
        y1_reg       <= y1_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        neg_reg      <= neg_next;
        dcnt_reg     <= dcnt_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_value        = m_value_reg;
    assign m_status       = m_status_reg;
    assign m_vertex_count = m_count_reg;

endmodule

@@ hw/rtl/plbt_checker.sv @@
module plbt_checker #(
    parameter int TABLE_DEPTH = plbt_pkg::TABLE_DEPTH_DEF
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [plbt_pkg::Y_WIDTH-1:0] m_value,
    input logic [plbt_pkg::STATUS_WIDTH-1:0]   m_status,
    input logic [$clog2(TABLE_DEPTH+1)-1:0]    m_vertex_count
);

    // one request in flight: the block is busy the cycle after taking one
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("accepted a request while busy");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != plbt_pkg::STAT_OK) |-> (m_value == '0))
        else $error("failed request returned a nonzero value");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_vertex_count} <= ($clog2(TABLE_DEPTH+1)+1)'(TABLE_DEPTH)))
        else $error("vertex count beyond table depth");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status) && $stable(m_value)))
        else $error("result dropped or changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("not idle after reset");

endmodule

bind piecewise_linear_breakpoint_table_core plbt_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_plbt_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_value        (m_value),
    .m_status       (m_status),
    .m_vertex_count (m_vertex_count)
);

@@ test/piecewise_linear_breakpoint_table_core_tb.sv @@
module piecewise_linear_breakpoint_table_core_tb;

    localparam int DEPTH = plbt_pkg::TABLE_DEPTH_DEF;
    localparam int CW    = plbt_pkg::COORD_WIDTH_DEF;

    typedef struct {
        logic [plbt_pkg::MODE_WIDTH-1:0] mode;
        logic signed [CW-1:0] x;
        logic signed [15:0]   y;
        logic signed [CW-1:0] new_x;
        logic signed [15:0]   new_y;
    } request_t;

    typedef struct {
        logic signed [15:0]                  value;
        logic [plbt_pkg::STATUS_WIDTH-1:0]   status;
        logic [5:0]                          vertex_count;
    } answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [plbt_pkg::MODE_WIDTH-1:0] s_mode = '0;
    logic signed [CW-1:0] s_x = '0;
    logic signed [15:0] s_y = '0;
    logic signed [CW-1:0] s_new_x = '0;
    logic signed [15:0] s_new_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_value;
    logic [plbt_pkg::STATUS_WIDTH-1:0] m_status;
    logic [5:0] m_vertex_count;

    piecewise_linear_breakpoint_table_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode), .s_x(s_x),
        .s_y(s_y), .s_new_x(s_new_x), .s_new_y(s_new_y),
        .m_valid(m_valid), .m_ready(m_ready), .m_value(m_value),
        .m_status(m_status), .m_vertex_count(m_vertex_count)
    );

    always #2 aclk = ~aclk;

    request_t pending_reqs[$];
    answer_t  expected_answers[$];
    int errors = 0;
    bit stimulus_done = 0;

    // predictor's own copy of the table
    int tbl_x[DEPTH];
    int tbl_y[DEPTH];
    int tbl_n = 0;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic void add_req(input request_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic int find_vertex(input int xv, input int yv);
        for (int i = 0; i < tbl_n; i++)
            if (tbl_x[i] == xv && (yv < 0 || tbl_y[i] == yv)) return i;
        return -1;
    endfunction

    function automatic void place_vertex(input int pos, input int xv, input int yv);
        for (int i = tbl_n; i > pos; i--) begin
            tbl_x[i] = tbl_x[i-1];
            tbl_y[i] = tbl_y[i-1];
        end
        tbl_x[pos] = xv;
        tbl_y[pos] = yv;
        tbl_n++;
    endfunction

    function automatic answer_t apply_request(input request_t r);
        answer_t a;
        int xv, yv, p, nx;
        longint num;
        bit done;
        xv = int'(r.x);
        yv = int'(r.y);
        a.value = '0;
        a.status = plbt_pkg::STAT_OK;
        done = 0;
        case (r.mode)
            plbt_pkg::MODE_EVAL: begin
                if (tbl_n == 0 || xv < tbl_x[0] || xv > tbl_x[tbl_n-1]) begin
                    a.status = plbt_pkg::STAT_RANGE;
                end else begin
                    for (int i = 0; i < tbl_n && !done; i++) begin
                        if (tbl_x[i] == xv) begin
                            a.value = 16'(tbl_y[i]);
                            done = 1;
                        end else if (tbl_x[i] > xv) begin
                            num = longint'(xv - tbl_x[i-1]) * (tbl_y[i] - tbl_y[i-1]);
                            a.value = 16'(tbl_y[i-1] + num / (tbl_x[i] - tbl_x[i-1]));
                            done = 1;
                        end
                    end
                end
            end
            plbt_pkg::MODE_INSERT: begin
                if (tbl_n >= DEPTH) begin
                    a.status = plbt_pkg::STAT_FULL;
                end else begin
                    for (int i = 0; i < tbl_n && !done; i++) begin
                        if (tbl_x[i] == xv) begin
                            done = 1;
                            if (xv > -32768 && (i == 0 || tbl_x[i-1] < xv - 1))
                                place_vertex(i, xv - 1, yv);
                            else if (xv < 32767 && (i + 1 >= tbl_n || tbl_x[i+1] > xv + 1))
                                place_vertex(i + 1, xv + 1, yv);
                            else
                                a.status = plbt_pkg::STAT_NO_ROOM;
                        end else if (tbl_x[i] > xv) begin
                            done = 1;
                            place_vertex(i, xv, yv);
                        end
                    end
                    if (!done) place_vertex(tbl_n, xv, yv);
                end
            end
            plbt_pkg::MODE_REMOVE: begin
                p = find_vertex(xv, yv);
                if (p < 0) begin
                    a.status = plbt_pkg::STAT_NOT_FOUND;
                end else begin
                    for (int i = p; i + 1 < tbl_n; i++) begin
                        tbl_x[i] = tbl_x[i+1];
                        tbl_y[i] = tbl_y[i+1];
                    end
                    tbl_n--;
                end
            end
            plbt_pkg::MODE_MOVE_X: begin
                p = find_vertex(xv, -1);
                if (p < 0) begin
                    a.status = plbt_pkg::STAT_NOT_FOUND;
                end else begin
                    nx = int'(r.new_x);
                    if (p > 0 && nx < tbl_x[p-1] + 1) nx = tbl_x[p-1] + 1;
                    if (p + 1 < tbl_n && nx > tbl_x[p+1] - 1) nx = tbl_x[p+1] - 1;
                    tbl_x[p] = nx;
                end
            end
            plbt_pkg::MODE_SET_Y: begin
                p = find_vertex(xv, yv);
                if (p < 0) a.status = plbt_pkg::STAT_NOT_FOUND;
                else tbl_y[p] = int'(r.new_y);
            end
            default: ;
        endcase
        a.vertex_count = tbl_n[5:0];
        return a;
    endfunction

    function automatic request_t make_req(input logic [plbt_pkg::MODE_WIDTH-1:0] m,
                                          input int xv, input int yv,
                                          input int nx, input int ny);
        request_t r;
        r.mode = m;
        r.x = CW'(xv);
        r.y = 16'(yv);
        r.new_x = CW'(nx);
        r.new_y = 16'(ny);
        return r;
    endfunction

    // x values crowd into a narrow window so clashes and hits are common
    function automatic int pick_x(input int centre);
        case ($urandom_range(0, 9))
            0: return int'($urandom_range(0, 65535)) - 32768;
            1: return $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 3))
                                            : -32768 + int'($urandom_range(0, 3));
            default: return centre + int'($urandom_range(0, 80)) - 40;
        endcase
    endfunction

    function automatic int pick_y();
        if ($urandom_range(0, 3) == 0) return -1 - int'($urandom_range(0, 200));
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    initial begin
        int centre, m;
        logic [plbt_pkg::MODE_WIDTH-1:0] mode_pick;
        // directed part
        add_req(make_req(plbt_pkg::MODE_EVAL, 0, 0, 0, 0));
        add_req(make_req(plbt_pkg::MODE_REMOVE, 5, -1, 0, 0));
        add_req(make_req(plbt_pkg::MODE_MOVE_X, 5, 0, 9, 0));
        add_req(make_req(plbt_pkg::MODE_SET_Y, 5, -1, 0, 7));
        add_req(make_req(plbt_pkg::MODE_INSERT, 10, 32767, 0, 0));
        add_req(make_req(plbt_pkg::MODE_EVAL, 10, 0, 0, 0));
        add_req(make_req(plbt_pkg::MODE_EVAL, 11, 0, 0, 0));
        add_req(make_req(plbt_pkg::MODE_INSERT, 10, -32768, 0, 0));
        add_req(make_req(plbt_pkg::MODE_INSERT, 10, 100, 0, 0));
        add_req(make_req(plbt_pkg::MODE_INSERT, 10, 200, 0, 0));
        add_req(make_req(plbt_pkg::MODE_INSERT, -32768, 300, 0, 0));
        add_req(make_req(plbt_pkg::MODE_INSERT, 32767, -300, 0, 0));
        add_req(make_req(plbt_pkg::MODE_INSERT, 32767, 1, 0, 0));
        add_req(make_req(plbt_pkg::MODE_EVAL, 0, 0, 0, 0));
        add_req(make_req(plbt_pkg::MODE_EVAL, 20000, 0, 0, 0));
        add_req(make_req(plbt_pkg::MODE_REMOVE, 10, 55, 0, 0));
        add_req(make_req(plbt_pkg::MODE_MOVE_X, 10, 0, -32768, 0));
        add_req(make_req(plbt_pkg::MODE_MOVE_X, 9, 0, 32767, 0));
        add_req(make_req(plbt_pkg::MODE_SET_Y, 11, 200, 0, -32768));
        add_req(make_req(3'd5, 0, 0, 0, 0));
        add_req(make_req(3'd7, -1, -1, -1, -1));
        for (int i = 0; i < 28; i++)
            add_req(make_req(plbt_pkg::MODE_INSERT, i * 3, i * 50, 0, 0));
        add_req(make_req(plbt_pkg::MODE_EVAL, 4, 0, 0, 0));
        // random part: phases alternate between growing and shrinking the table
        centre = 0;
        for (int i = 0; i < 1900; i++) begin
            if (i % 150 == 0) centre = int'($urandom_range(0, 60000)) - 30000;
            m = int'($urandom_range(0, 99));
            if ((i / 150) % 2 == 0)
                mode_pick = (m < 40) ? plbt_pkg::MODE_INSERT
                          : (m < 70) ? plbt_pkg::MODE_EVAL
                          : (m < 80) ? plbt_pkg::MODE_REMOVE
                          : (m < 88) ? plbt_pkg::MODE_MOVE_X
                          : (m < 97) ? plbt_pkg::MODE_SET_Y
                          : 3'($urandom_range(5, 7));
            else
                mode_pick = (m < 15) ? plbt_pkg::MODE_INSERT
                          : (m < 45) ? plbt_pkg::MODE_EVAL
                          : (m < 75) ? plbt_pkg::MODE_REMOVE
                          : (m < 85) ? plbt_pkg::MODE_MOVE_X
                          : (m < 97) ? plbt_pkg::MODE_SET_Y
                          : 3'($urandom_range(5, 7));
            add_req(make_req(mode_pick, pick_x(centre), pick_y(),
                             $urandom_range(0, 1) ? pick_x(centre)
                             : int'($urandom_range(0, 65535)) - 32768,
                             int'($urandom_range(0, 65535)) - 32768));
        end
        stimulus_done = 1;
    end

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
            // hold
        end else begin
            if (s_valid)
                expected_answers.insert(expected_answers.size(),
                                        apply_request(pending_reqs.pop_front()));
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !(s_valid && pending_reqs.size() == 1)) begin
                if (burst_left == 0) begin
                    burst_left = int'($urandom_range(1, 12));
                    gap_left = $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(1, 90));
                end
                burst_left--;
                s_valid <= 1'b1;
                // the head item becomes the next one once the current one leaves
                s_mode <= pending_reqs[0].mode;
                s_x <= pending_reqs[0].x;
                s_y <= pending_reqs[0].y;
                s_new_x <= pending_reqs[0].new_x;
                s_new_y <= pending_reqs[0].new_y;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor with its own stall pattern
    int stall_phase = 0;
    always @(posedge aclk) begin
        answer_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_answers.size() == 0) begin
                    report("unexpected result, status", int'(m_status), 0);
                end else begin
                    want = expected_answers.pop_front();
                    if (m_value !== want.value)
                        report("value", int'(m_value), int'(want.value));
                    if (m_status !== want.status)
                        report("status", int'(m_status), int'(want.status));
                    if (m_vertex_count !== want.vertex_count)
                        report("vertex_count", int'(m_vertex_count),
                               int'(want.vertex_count));
                end
            end
            stall_phase = (stall_phase + 1) % 400;
            if (stall_phase < 100) m_ready <= 1'b1;
            else if (stall_phase < 200) m_ready <= ($urandom_range(0, 3) != 0);
            else m_ready <= ($urandom_range(0, 4) == 0);
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        wait (stimulus_done && pending_reqs.size() == 0 && !s_valid);
        wait (expected_answers.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0 && expected_answers.size() == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #10000000;
        $display("FAIL");
        $finish;
    end
endmodule

@@ files.f @@
hw/rtl/plbt_pkg.sv
hw/rtl/plbt_cell.sv
hw/rtl/plbt_chain.sv
hw/rtl/piecewise_linear_breakpoint_table_core.sv
hw/rtl/plbt_checker.sv
test/piecewise_linear_breakpoint_table_core_tb.sv
